[rtl/ppcsg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pattern pack CRC/sum generator package
// Shared widths, word kind codes, register indexes, reset values and the
// step counts of the serial arithmetic units.
// ----------------------------------------------------------------------------
package ppcsg_pkg;

	localparam int WORD_W   = 32;
	localparam int OFFS_W   = 31;
	localparam int PACK_W   = 16;
	localparam int CRC_W    = 16;
	localparam int KIND_W   = 2;
	localparam int CFG_IDX_W = 3;

	// Word kinds on the output
	localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CRC  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SUM  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PACK_SIZE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAW_MOD    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MUL_FACTOR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_APPEND_CRC = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_APPEND_SUM = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_USE_EXT    = 3'd6;

	// Register reset values
	localparam logic [PACK_W-1:0] RST_PACK_SIZE  = 16'd1;
	localparam logic [WORD_W-1:0] RST_SAW_MOD    = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] RST_MUL_FACTOR = 32'd1;
	localparam logic [CRC_W-1:0]  RST_CRC_POLY   = 16'h8408;

	// Multiplier: one digit of the multiplier per cycle
	localparam int MUL_DIGIT = 4;
	localparam int MUL_STEPS = WORD_W / MUL_DIGIT;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);

	// Remainder: one dividend bit per cycle
	localparam int MOD_STEPS = WORD_W;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);

	// CRC: one byte per cycle
	localparam int CRC_DIGIT = 8;
	localparam int CRC_STEPS = WORD_W / CRC_DIGIT;
	localparam int CRC_CNT_W = $clog2(CRC_STEPS);

endpackage
`default_nettype wire

[rtl/ppcsg_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Digit-serial multiplier
// Wrapping 32-bit product, one 4-bit multiplier digit per cycle, least
// significant digit first.
// ----------------------------------------------------------------------------
module ppcsg_mul (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [ppcsg_pkg::WORD_W-1:0] multiplicand,
	input  wire logic [ppcsg_pkg::WORD_W-1:0] multiplier,
	output logic                             done,
	output logic [ppcsg_pkg::WORD_W-1:0]     product
);
	import ppcsg_pkg::*;

	logic [WORD_W-1:0]           acc_q;
	logic [WORD_W-1:0]           mcand_q;
	logic [WORD_W-1:0]           mplier_q;
	logic [MUL_CNT_W-1:0]        cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [WORD_W+MUL_DIGIT-1:0] part;

	// Partial product of the multiplicand and the current digit
	assign part = {{MUL_DIGIT{1'b0}}, mcand_q}
		* {{WORD_W{1'b0}}, mplier_q[MUL_DIGIT-1:0]};

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Accumulate and shift the operands
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= multiplicand;
			mplier_q <= multiplier;
		end else if (busy_q) begin
			acc_q    <= acc_q + part[WORD_W-1:0];
			mcand_q  <= mcand_q << MUL_DIGIT;
			mplier_q <= mplier_q >> MUL_DIGIT;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule
`default_nettype wire

[rtl/ppcsg_mod.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bit-serial remainder unit
// Restoring division, one dividend bit per cycle, most significant first.
// The modulus must be nonzero and stay stable while the unit runs.
// ----------------------------------------------------------------------------
module ppcsg_mod (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [ppcsg_pkg::WORD_W-1:0] dividend,
	input  wire logic [ppcsg_pkg::WORD_W-1:0] modulus,
	output logic                             done,
	output logic [ppcsg_pkg::WORD_W-1:0]     remainder
);
	import ppcsg_pkg::*;

	logic [WORD_W-1:0]    rem_q;
	logic [WORD_W-1:0]    dvd_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [WORD_W:0]      trial;
	logic [WORD_W:0]      diff;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, dvd_q[WORD_W-1]};
	assign diff  = trial - {1'b0, modulus};

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MOD_CNT_W'(MOD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Keep the difference when it does not go negative
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
			dvd_q <= dvd_q << 1;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

[rtl/ppcsg_crc.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte-serial CRC-16
// Unreflected CRC over the bytes of a word, least significant byte first,
// one byte per cycle. Holds the running CRC of the current pack.
// ----------------------------------------------------------------------------
module ppcsg_crc (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        clear,
	input  wire logic [ppcsg_pkg::WORD_W-1:0] word,
	input  wire logic [ppcsg_pkg::CRC_W-1:0]  poly,
	output logic                             done,
	output logic [ppcsg_pkg::CRC_W-1:0]      crc
);
	import ppcsg_pkg::*;

	logic [CRC_W-1:0]     crc_q;
	logic [WORD_W-1:0]    byte_q;
	logic [CRC_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	// One byte through the polynomial, most significant bit first
	function automatic logic [CRC_W-1:0] crc_byte(
		input logic [CRC_W-1:0]     crc_in,
		input logic [CRC_DIGIT-1:0] data,
		input logic [CRC_W-1:0]     p
	);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {data, {(CRC_W-CRC_DIGIT){1'b0}}};
		for (int b = 0; b < CRC_DIGIT; b++) begin
			c = c[CRC_W-1] ? ((c << 1) ^ p) : (c << 1);
		end
		return c;
	endfunction

	// Sequence the bytes and update the running CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			crc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (clear) begin
				crc_q <= '0;
			end
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				crc_q <= crc_byte(crc_q, byte_q[CRC_DIGIT-1:0], poly);
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CRC_CNT_W'(CRC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the word down one byte per step
	always_ff @(posedge clk) begin
		if (start) begin
			byte_q <= word;
		end else if (busy_q) begin
			byte_q <= byte_q >> CRC_DIGIT;
		end
	end

	assign done = done_q;
	assign crc  = crc_q;

endmodule
`default_nettype wire

[rtl/pattern_pack_crc_sum_generator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pattern pack CRC/sum generator
// Emits one data word per input item, either the external word or the
// pattern ((random_offset + word_count) * mul_factor) mod saw_modulus, and
// after each pack of pack_size words an optional CRC-16 and sum trailer.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A generated word passes through the
// accept state, the 4-bit digit-serial multiplier, the bit-serial remainder
// unit (skipped when saw_modulus is 0), the byte-serial CRC and the load of
// the output register. An external word skips both arithmetic units. Each
// trailer is loaded into the output register from its own state, and the
// next item is taken as soon as the last result of the current one sits in
// the output register, even while that result is stalled.
// ----------------------------------------------------------------------------
module pattern_pack_crc_sum_generator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [ppcsg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ppcsg_pkg::WORD_W-1:0]    cfg_data,
	// input channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [ppcsg_pkg::WORD_W-1:0]    external_word,
	input  wire logic [ppcsg_pkg::OFFS_W-1:0]    random_offset,
	// output channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [ppcsg_pkg::WORD_W-1:0]        word_value,
	output logic [ppcsg_pkg::KIND_W-1:0]        word_kind,
	output logic                                last_of_run
);
	import ppcsg_pkg::*;

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
	localparam logic [ST_W-1:0] ST_MUL  = 3'd1;
	localparam logic [ST_W-1:0] ST_MOD  = 3'd2;
	localparam logic [ST_W-1:0] ST_CRC  = 3'd3;
	localparam logic [ST_W-1:0] ST_DATA = 3'd4;
	localparam logic [ST_W-1:0] ST_CRCW = 3'd5;
	localparam logic [ST_W-1:0] ST_SUMW = 3'd6;

	// configuration registers
	logic [PACK_W-1:0] pack_size_q;
	logic [WORD_W-1:0] saw_modulus_q;
	logic [WORD_W-1:0] mul_factor_q;
	logic [CRC_W-1:0]  crc_poly_q;
	logic              append_crc_q;
	logic              append_sum_q;
	logic              use_external_q;

	// state
	logic [ST_W-1:0]   state_q;
	logic [WORD_W-1:0] word_count_q;
	logic [PACK_W-1:0] pack_pos_q;
	logic [WORD_W-1:0] sum_q;
	logic [WORD_W-1:0] val_q;

	// output register
	logic              out_valid_q;
	logic [WORD_W-1:0] word_value_q;
	logic [KIND_W-1:0] word_kind_q;
	logic              last_q;

	logic              in_xfer;
	logic              slot_free;
	logic [WORD_W-1:0] base;
	logic [PACK_W:0]   limit;
	logic              pack_end;
	logic              any_trailer;

	logic              mul_start;
	logic              mul_done;
	logic [WORD_W-1:0] product;
	logic              mod_start;
	logic              mod_done;
	logic [WORD_W-1:0] remainder;
	logic              crc_start;
	logic              crc_clear;
	logic              crc_done;
	logic [CRC_W-1:0]  crc;
	logic [WORD_W-1:0] crc_word;

	assign in_stall    = (state_q != ST_IDLE);
	assign in_xfer     = in_valid && !in_stall;
	assign slot_free   = !out_valid_q || !out_stall;
	assign base        = {1'b0, random_offset} + word_count_q;
	assign limit       = (pack_size_q == '0) ? (PACK_W+1)'(1) : {1'b0, pack_size_q};
	assign pack_end    = ({1'b0, pack_pos_q} + 1'b1) >= limit;
	assign any_trailer = append_crc_q || append_sum_q;

	// Unit starts
	assign mul_start = in_xfer && !use_external_q;
	assign mod_start = (state_q == ST_MUL) && mul_done && (saw_modulus_q != '0);
	assign crc_start = (in_xfer && use_external_q)
		|| ((state_q == ST_MUL) && mul_done && (saw_modulus_q == '0))
		|| ((state_q == ST_MOD) && mod_done);
	assign crc_word  = (state_q == ST_IDLE) ? external_word
		: (state_q == ST_MUL) ? product : remainder;

	// Clear the pack CRC once its last result is loaded
	assign crc_clear = slot_free && (
		((state_q == ST_DATA) && pack_end && !any_trailer)
		|| ((state_q == ST_CRCW) && !append_sum_q)
		|| (state_q == ST_SUMW));

	ppcsg_mul u_mul (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mul_start),
		.multiplicand (base),
		.multiplier   (mul_factor_q),
		.done         (mul_done),
		.product      (product)
	);

	ppcsg_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (product),
		.modulus   (saw_modulus_q),
		.done      (mod_done),
		.remainder (remainder)
	);

	ppcsg_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (crc_start),
		.clear  (crc_clear),
		.word   (crc_word),
		.poly   (crc_poly_q),
		.done   (crc_done),
		.crc    (crc)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_size_q    <= RST_PACK_SIZE;
			saw_modulus_q  <= RST_SAW_MOD;
			mul_factor_q   <= RST_MUL_FACTOR;
			crc_poly_q     <= RST_CRC_POLY;
			append_crc_q   <= 1'b0;
			append_sum_q   <= 1'b0;
			use_external_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PACK_SIZE:  pack_size_q    <= cfg_data[PACK_W-1:0];
				REG_SAW_MOD:    saw_modulus_q  <= cfg_data;
				REG_MUL_FACTOR: mul_factor_q   <= cfg_data;
				REG_CRC_POLY:   crc_poly_q     <= cfg_data[CRC_W-1:0];
				REG_APPEND_CRC: append_crc_q   <= cfg_data[0];
				REG_APPEND_SUM: append_sum_q   <= cfg_data[0];
				REG_USE_EXT:    use_external_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer, pack tracking and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			word_count_q <= '0;
			pack_pos_q   <= '0;
			sum_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// drop the output word once it is transferred
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						word_count_q <= word_count_q + 1'b1;
						state_q      <= use_external_q ? ST_CRC : ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= (saw_modulus_q == '0) ? ST_CRC : ST_MOD;
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						state_q <= ST_CRC;
					end
				end
				ST_CRC: begin
					if (crc_done) begin
						state_q <= ST_DATA;
					end
				end
				ST_DATA: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (pack_end) begin
							pack_pos_q <= '0;
							if (!any_trailer) begin
								sum_q   <= '0;
								state_q <= ST_IDLE;
							end else begin
								sum_q   <= sum_q + val_q;
								state_q <= append_crc_q ? ST_CRCW : ST_SUMW;
							end
						end else begin
							pack_pos_q <= pack_pos_q + 1'b1;
							sum_q      <= sum_q + val_q;
							state_q    <= ST_IDLE;
						end
					end
				end
				ST_CRCW: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (append_sum_q) begin
							state_q <= ST_SUMW;
						end else begin
							sum_q   <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SUMW: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						sum_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the finished data word
	always_ff @(posedge clk) begin
		if (in_xfer && use_external_q) begin
			val_q <= external_word;
		end else if ((state_q == ST_MUL) && mul_done) begin
			val_q <= product;
		end else if ((state_q == ST_MOD) && mod_done) begin
			val_q <= remainder;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (state_q == ST_DATA) begin
				word_value_q <= val_q;
				word_kind_q  <= KIND_DATA;
				last_q       <= !(pack_end && any_trailer);
			end else if (state_q == ST_CRCW) begin
				word_value_q <= {{(WORD_W-CRC_W){1'b0}}, crc};
				word_kind_q  <= KIND_CRC;
				last_q       <= !append_sum_q;
			end else if (state_q == ST_SUMW) begin
				word_value_q <= sum_q;
				word_kind_q  <= KIND_SUM;
				last_q       <= 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign word_value  = word_value_q;
	assign word_kind   = word_kind_q;
	assign last_of_run = last_q;

endmodule
`default_nettype wire
